FILE: hw/rtl/pskw_pkg.sv
`default_nettype none

package pskw_pkg;

  // fixed field widths
  localparam int PROJ_W   = 39;
  localparam int ID_W     = 10;
  localparam int ELEM_W   = 16;
  localparam int DIR_W    = 16;
  localparam int DIDX_W   = 6;
  localparam int K_CFG_W  = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  // operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // result status codes
  localparam logic [1:0] ST_RESULT = 2'd0;
  localparam logic [1:0] ST_ADDED  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  // one table entry
  typedef struct packed {
    logic signed [PROJ_W-1:0] proj;
    logic [ID_W-1:0]          id;
  } entry_t;

  // dot product result towards the controller
  typedef struct packed {
    logic                     done;
    logic signed [PROJ_W-1:0] proj;
  } dot_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pskw_dot.sv
`default_nettype none

module pskw_dot #(
  parameter int DIM = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load_en,
  input  wire logic [pskw_pkg::DIDX_W-1:0]   load_idx,
  input  wire logic [pskw_pkg::DIR_W-1:0]    load_val,
  input  wire logic                          elem_en,
  input  wire logic [pskw_pkg::ELEM_W-1:0]   elem_val,
  input  wire logic                          elem_last,
  output pskw_pkg::dot_res_t                 res
);
  import pskw_pkg::*;

  localparam int DAW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int PW  = $clog2(DIM + 1);
  localparam int IW  = ((DAW > DIDX_W) ? DAW : DIDX_W) + 1;

  logic [DIR_W-1:0] dir_mem [DIM];
  logic [DIR_W-1:0] dir_q;

  logic [PW-1:0]            pos_r, pos_nxt;
  logic signed [PROJ_W-1:0] acc_r, acc_nxt;
  logic                     stage_v_r, stage_last_r, stage_hit_r;
  logic [ELEM_W-1:0]        elem_r;
  logic                     in_range;
  logic signed [ELEM_W+DIR_W:0] prod;
  logic signed [PROJ_W-1:0] sum;
  logic [IW-1:0]            load_idx_w;

  assign in_range   = pos_r < PW'(DIM);
  assign load_idx_w = IW'(load_idx);

  // direction memory, registered read
  always_ff @(posedge clk) begin
    if (load_en && (load_idx_w < IW'(DIM))) begin
      dir_mem[load_idx_w[DAW-1:0]] <= load_val;
    end
    if (elem_en) begin
      dir_q <= dir_mem[pos_r[DAW-1:0]];
    end
  end

  // multiply and accumulate in the cycle after the read
  assign prod = $signed(elem_r) * $signed({1'b0, dir_q});
  assign sum  = stage_hit_r ? (acc_r + PROJ_W'(prod)) : acc_r;

  always_comb begin
    acc_nxt = acc_r;
    pos_nxt = pos_r;
    if (elem_en && in_range) begin
      pos_nxt = pos_r + PW'(1);
    end
    if (stage_v_r) begin
      acc_nxt = stage_last_r ? '0 : sum;
    end
    if (stage_v_r && stage_last_r) begin
      pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      acc_r     <= '0;
      stage_v_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      acc_r     <= acc_nxt;
      stage_v_r <= elem_en;
    end
  end

  always_ff @(posedge clk) begin
    if (elem_en) begin
      elem_r       <= elem_val;
      stage_last_r <= elem_last;
      stage_hit_r  <= in_range;
    end
  end

  assign res.done = stage_v_r && stage_last_r;
  assign res.proj = sum;

endmodule

`default_nettype wire

FILE: hw/rtl/pskw_tbl.sv
`default_nettype none

module pskw_tbl #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              wr_en,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0]    wr_addr,
  input  wire pskw_pkg::entry_t                  wr_data,
  input  wire logic                              rd_en,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0]    rd_addr,
  output pskw_pkg::entry_t                       rd_data
);
  import pskw_pkg::*;

  entry_t mem [TABLE_DEPTH];

  // sorted entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/projection_sorted_knn_window.sv
// Projection-sorted nearest neighbour index.
// Input stream (in_*): one transaction per element. tuser selects the kind:
// direction load, add-vector element or query-vector element; tlast marks the
// final element of a vector. Each element takes the direction memory read,
// then one multiply-accumulate. On the last element of an add, the entry is
// inserted from the top of the table downwards, with a read and then a write
// for each entry moved. A query runs a binary search (a read and a compare per
// step) and then scores up to k + 2 candidate windows, each with two reads and
// a compare, then emits up to k entry numbers. Full and empty cases give one
// status result.
// Result stream (out_*): entry number in tdata, status in tuser, tlast on the
// final result of a transaction. Results sit in an output register; a stalled
// receiver holds the controller until the register is taken, and the block
// returns to idle once the final result is registered.
// Reset clears the entry count, accumulator, element position and sets k to 1;
// table and direction memories are not cleared.
// cfg_we writes k (clamped to 1..K_MAX); write only while the block is idle.
`default_nettype none

module projection_sorted_knn_window #(
  parameter int DIM         = 64,
  parameter int TABLE_DEPTH = 1024,
  parameter int K_MAX       = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // direction_index, direction_value, element_value, zero pad
  input  wire logic [pskw_pkg::IN_DATA_W-1:0]       in_tdata,
  // operation
  input  wire logic [1:0]                           in_tuser,
  input  wire logic                                 in_tlast,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // entry_id, zero pad
  output logic [pskw_pkg::OUT_DATA_W-1:0]           out_tdata,
  // status
  output logic [1:0]                                out_tuser,
  output logic                                      out_tlast,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  input  wire logic                                 cfg_we,
  input  wire logic [pskw_pkg::K_CFG_W-1:0]         cfg_wdata
);
  import pskw_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam int KW = $clog2(K_MAX + 1);
  localparam int SW = CW + KW + 1;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MAC     = 4'd1;
  localparam logic [3:0] S_INS_RD  = 4'd2;
  localparam logic [3:0] S_INS_CMP = 4'd3;
  localparam logic [3:0] S_BS_RD   = 4'd4;
  localparam logic [3:0] S_BS_CMP  = 4'd5;
  localparam logic [3:0] S_W_RDL   = 4'd6;
  localparam logic [3:0] S_W_RDR   = 4'd7;
  localparam logic [3:0] S_W_CMP   = 4'd8;
  localparam logic [3:0] S_EMIT_RD = 4'd9;
  localparam logic [3:0] S_EMIT_WR = 4'd10;
  localparam logic [3:0] S_RESP    = 4'd11;

  logic [3:0]               state_r, state_nxt;
  logic [1:0]               op_r, op_nxt;
  logic signed [PROJ_W-1:0] p_r, p_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [KW-1:0]            k_r, k_nxt;
  logic [CW-1:0]            i_r, i_nxt, lo_r, lo_nxt, hi_r, hi_nxt, end_r, end_nxt;
  logic [AW-1:0]            best_r, best_nxt;
  logic                     have_r, have_nxt;
  logic [PROJ_W:0]          bestd_r, bestd_nxt, dl_r, dl_nxt;
  logic [KW-1:0]            j_r, j_nxt, cnt_r, cnt_nxt;
  logic [1:0]               resp_st_r, resp_st_nxt;
  logic [ID_W-1:0]          resp_id_r, resp_id_nxt;

  logic                     out_valid_r, out_last_r;
  logic [ID_W-1:0]          out_id_r;
  logic [1:0]               out_st_r;
  logic                     out_load, out_last_n;
  logic [ID_W-1:0]          out_id_n;
  logic [1:0]               out_st_n;

  logic                     in_acc, is_elem, slot_free;
  dot_res_t                 dot_res;
  logic                     wr_en, rd_en;
  logic [AW-1:0]            wr_addr, rd_addr;
  entry_t                   wr_data, rd_data, new_entry;

  logic [SW-1:0]            mid_w, pos_w, k_w, n_w, i_w, lim_w, end_w, best_w, rem_w;
  logic signed [PROJ_W:0]   diff;
  logic [PROJ_W:0]          absd, dmax;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign is_elem   = (in_tuser == OP_ADD) || (in_tuser == OP_QUERY);
  assign slot_free = !out_valid_r || out_tready;

  pskw_dot #(.DIM(DIM)) u_dot (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_en   (in_acc && (in_tuser == OP_LOAD)),
    .load_idx  (in_tdata[5:0]),
    .load_val  (in_tdata[21:6]),
    .elem_en   (in_acc && is_elem),
    .elem_val  (in_tdata[37:22]),
    .elem_last (in_tlast),
    .res       (dot_res)
  );

  pskw_tbl #(.TABLE_DEPTH(TABLE_DEPTH)) u_tbl (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // shared index arithmetic
  assign k_w    = SW'(k_r);
  assign n_w    = SW'(count_r);
  assign i_w    = SW'(i_r);
  assign mid_w  = (SW'(lo_r) + SW'(hi_r)) >> 1;
  assign pos_w  = SW'(lo_r);
  assign lim_w  = (pos_w + SW'(1) < n_w - SW'(1)) ? pos_w + SW'(1) : n_w - SW'(1);
  assign end_w  = SW'(end_r);
  assign best_w = SW'(best_r);
  assign rem_w  = n_w - best_w;

  // distance of the entry just read from the query projection
  assign diff = {rd_data.proj[PROJ_W-1], rd_data.proj} - {p_r[PROJ_W-1], p_r};
  assign absd = diff[PROJ_W] ? (PROJ_W+1)'(0) - diff : diff;
  assign dmax = (dl_r > absd) ? dl_r : absd;

  assign new_entry.proj = p_r;
  assign new_entry.id   = ID_W'(count_r);

  // neighbour count, clamped on write
  always_comb begin
    k_nxt = k_r;
    if (cfg_we) begin
      if (cfg_wdata == '0) begin
        k_nxt = KW'(1);
      end else if (int'(cfg_wdata) > K_MAX) begin
        k_nxt = KW'(K_MAX);
      end else begin
        k_nxt = KW'(cfg_wdata);
      end
    end
  end

  // controller
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    p_nxt       = p_r;
    count_nxt   = count_r;
    i_nxt       = i_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    end_nxt     = end_r;
    best_nxt    = best_r;
    have_nxt    = have_r;
    bestd_nxt   = bestd_r;
    dl_nxt      = dl_r;
    j_nxt       = j_r;
    cnt_nxt     = cnt_r;
    resp_st_nxt = resp_st_r;
    resp_id_nxt = resp_id_r;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = new_entry;
    rd_en       = 1'b0;
    rd_addr     = '0;
    out_load    = 1'b0;
    out_id_n    = resp_id_r;
    out_st_n    = resp_st_r;
    out_last_n  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && is_elem) begin
          op_nxt    = in_tuser;
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        if (dot_res.done) begin
          p_nxt = dot_res.proj;
          if (op_r == OP_ADD) begin
            if (count_r >= CW'(TABLE_DEPTH)) begin
              resp_st_nxt = ST_FULL;
              resp_id_nxt = '0;
              state_nxt   = S_RESP;
            end else begin
              i_nxt     = count_r;
              state_nxt = S_INS_RD;
            end
          end else if (count_r == '0) begin
            resp_st_nxt = ST_EMPTY;
            resp_id_nxt = '0;
            state_nxt   = S_RESP;
          end else begin
            lo_nxt    = '0;
            hi_nxt    = count_r;
            state_nxt = S_BS_RD;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      // insertion: shift larger entries up from the top
      S_INS_RD: begin
        if (i_r == '0) begin
          wr_en       = 1'b1;
          wr_addr     = '0;
          count_nxt   = count_r + CW'(1);
          resp_st_nxt = ST_ADDED;
          resp_id_nxt = ID_W'(count_r);
          state_nxt   = S_RESP;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = AW'(i_r - CW'(1));
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        wr_en   = 1'b1;
        wr_addr = AW'(i_r);
        if (rd_data.proj > p_r) begin
          wr_data   = rd_data;
          i_nxt     = i_r - CW'(1);
          state_nxt = S_INS_RD;
        end else begin
          count_nxt   = count_r + CW'(1);
          resp_st_nxt = ST_ADDED;
          resp_id_nxt = ID_W'(count_r);
          state_nxt   = S_RESP;
        end
      end
      // lower-bound binary search
      S_BS_RD: begin
        if (lo_r < hi_r) begin
          rd_en     = 1'b1;
          rd_addr   = AW'(mid_w);
          state_nxt = S_BS_CMP;
        end else begin
          i_nxt     = CW'(pos_w - ((pos_w < k_w) ? pos_w : k_w));
          end_nxt   = CW'(lim_w);
          have_nxt  = 1'b0;
          best_nxt  = '0;
          state_nxt = S_W_RDL;
        end
      end
      S_BS_CMP: begin
        if (rd_data.proj < p_r) begin
          lo_nxt = CW'(mid_w + SW'(1));
        end else begin
          hi_nxt = CW'(mid_w);
        end
        state_nxt = S_BS_RD;
      end
      // window scoring
      S_W_RDL: begin
        if (i_w > end_w) begin
          cnt_nxt   = KW'((rem_w < k_w) ? rem_w : k_w);
          j_nxt     = '0;
          state_nxt = S_EMIT_RD;
        end else if (i_w + k_w > n_w) begin
          i_nxt = i_r + CW'(1);
        end else begin
          rd_en     = 1'b1;
          rd_addr   = AW'(i_r);
          state_nxt = S_W_RDR;
        end
      end
      S_W_RDR: begin
        dl_nxt    = absd;
        rd_en     = 1'b1;
        rd_addr   = AW'(i_w + k_w - SW'(1));
        state_nxt = S_W_CMP;
      end
      S_W_CMP: begin
        if (!have_r || (dmax < bestd_r)) begin
          have_nxt  = 1'b1;
          best_nxt  = AW'(i_r);
          bestd_nxt = dmax;
        end
        i_nxt     = i_r + CW'(1);
        state_nxt = S_W_RDL;
      end
      // neighbour emission
      S_EMIT_RD: begin
        rd_en     = 1'b1;
        rd_addr   = AW'(best_w + SW'(j_r));
        state_nxt = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_id_n   = rd_data.id;
          out_st_n   = ST_RESULT;
          out_last_n = (j_r + KW'(1) == cnt_r);
          j_nxt      = j_r + KW'(1);
          state_nxt  = out_last_n ? S_IDLE : S_EMIT_RD;
        end
      end
      S_RESP: begin
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      k_r         <= KW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      k_r     <= k_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    p_r       <= p_nxt;
    i_r       <= i_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    end_r     <= end_nxt;
    best_r    <= best_nxt;
    have_r    <= have_nxt;
    bestd_r   <= bestd_nxt;
    dl_r      <= dl_nxt;
    j_r       <= j_nxt;
    cnt_r     <= cnt_nxt;
    resp_st_r <= resp_st_nxt;
    resp_id_r <= resp_id_nxt;
    if (out_load) begin
      out_id_r   <= out_id_n;
      out_st_r   <= out_st_n;
      out_last_r <= out_last_n;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_id_r);
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> (count_r == $past(count_r) + CW'(1)))
    else $error("entry count moved by more than one");

  a_window_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_W_RDR) |-> (i_w + k_w <= n_w))
    else $error("scored window runs past the table");

  a_emit_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_RD) |-> (best_w + SW'(j_r) < n_w))
    else $error("emitted entry beyond entry count");
`endif

endmodule

`default_nettype wire
